FILE: rtl/invariant_divisor_magic_division_defines.svh
// Assertion macros shared by the invariant divisor magic division RTL.
`ifndef INVARIANT_DIVISOR_MAGIC_DIVISION_DEFINES_SVH
`define INVARIANT_DIVISOR_MAGIC_DIVISION_DEFINES_SVH

// Same-cycle implication, sampled on i_clk and disabled while in reset.
`define IDMD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk and disabled while in reset.
`define IDMD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/idmd_pkg.sv
// Shared constants for the invariant divisor magic division block.
`timescale 1ns / 1ps

package idmd_pkg;

    // Dividend and quotient width.
    localparam int WORD_W = 64;
    // Half word, the operand width of the shared multiplier.
    localparam int HALF_W = WORD_W / 2;
    // Divisor and remainder width.
    localparam int DIV_W = 31;
    // Width of the iteration counter (one step per quotient bit of the reciprocal).
    localparam int CNT_W = $clog2(WORD_W);
    // Width of the shift amount.
    localparam int SHAMT_W = 5;
    // Number of partial products in one multiply-high.
    localparam int MUL_STEPS = 4;

endpackage

FILE: rtl/invariant_divisor_magic_division.sv
// Top level: 64-bit unsigned division by an invariant divisor via a magic reciprocal.
//
//   Channel   Direction  Handshake              Word
//   input     in         i_valid / o_stall      i_dividend
//   output    out        o_valid / i_stall      o_quotient, o_remainder
//   config    in         i_cfg_we               i_cfg_wdata (divisor)
//
// With d prepared, a word runs all its steps (only shift and remainder for a divisor
// of one or a power of two) before the next is taken. The single 32x32 multiplier
// forms four partial products of the multiply-high, then the remainder product. A new
// divisor adds a search for ceil(log2 d) and, for a reciprocal, a restoring division.
// Reset is synchronous, active low. A finished word waits in the output register while
// the next is computed; a second holds in its last step and keeps o_stall high.
`timescale 1ns / 1ps
`include "invariant_divisor_magic_division_defines.svh"

module invariant_divisor_magic_division (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [idmd_pkg::DIV_W-1:0]   i_cfg_wdata,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [idmd_pkg::WORD_W-1:0]  i_dividend,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [idmd_pkg::WORD_W-1:0]  o_quotient,
    output logic [idmd_pkg::DIV_W-1:0]   o_remainder
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP_LOG,
        S_PREP_DIV,
        S_PREP_FIN,
        S_MUL,
        S_Q_SUB,
        S_Q_ADD,
        S_Q_SHF,
        S_R_MUL,
        S_R_SUB
    } t_state;

    t_state                                r_state;
    logic [idmd_pkg::DIV_W-1:0]            r_divisor;
    logic [idmd_pkg::DIV_W-1:0]            r_prepared;
    logic [idmd_pkg::WORD_W-1:0]           r_magic;
    logic [idmd_pkg::SHAMT_W-1:0]          r_shamt;
    logic                                  r_shift_only;
    logic [idmd_pkg::WORD_W-1:0]           r_x;
    logic [idmd_pkg::DIV_W-1:0]            r_d;
    logic [idmd_pkg::DIV_W:0]              r_pow;
    logic [idmd_pkg::SHAMT_W-1:0]          r_lg;
    logic [idmd_pkg::DIV_W-1:0]            r_rem;
    logic [idmd_pkg::CNT_W-1:0]            r_cnt;
    logic [2*idmd_pkg::HALF_W-1:0]         r_pp;
    logic [1:0]                            r_pp_off;
    logic [2*idmd_pkg::WORD_W-1:0]         r_acc;
    logic [idmd_pkg::WORD_W-1:0]           r_tmp;
    logic [idmd_pkg::WORD_W-1:0]           r_q;
    logic                                  r_o_valid;
    logic [idmd_pkg::WORD_W-1:0]           r_o_quotient;
    logic [idmd_pkg::DIV_W-1:0]            r_o_remainder;

    logic [idmd_pkg::DIV_W-1:0]            d_eff;
    logic                                  in_accept;
    logic                                  out_free;
    logic [idmd_pkg::HALF_W-1:0]           mul_a;
    logic [idmd_pkg::HALF_W-1:0]           mul_b;
    logic [2*idmd_pkg::HALF_W-1:0]         mul_p;
    logic [1:0]                            pp_off;
    logic [2*idmd_pkg::WORD_W-1:0]         acc_sum;
    logic [idmd_pkg::DIV_W:0]              d_ext;
    logic                                  pow_lt;
    logic                                  pow_eq;
    logic [idmd_pkg::DIV_W:0]              rem_dbl;
    logic [idmd_pkg::DIV_W:0]              rem_sub;
    logic                                  rem_ge;
    logic [idmd_pkg::WORD_W-1:0]           t_hi;
    logic [idmd_pkg::WORD_W-1:0]           shf_src;
    logic [idmd_pkg::SHAMT_W-1:0]          shf_amt;

    // A zero divisor behaves like a divisor of one.
    assign d_eff = (r_divisor == '0) ? idmd_pkg::DIV_W'(1) : r_divisor;

    // Handshakes: dividends are taken only while the sequencer is idle.
    assign o_stall   = (r_state != S_IDLE);
    assign in_accept = i_valid && !o_stall;
    assign out_free  = !r_o_valid || !i_stall;

    // Shared 32x32 multiplier: partial products of x*magic, then q*d for the remainder.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_MUL: begin
                mul_a = r_cnt[1] ? r_x[idmd_pkg::WORD_W-1:idmd_pkg::HALF_W]
                                 : r_x[idmd_pkg::HALF_W-1:0];
                mul_b = r_cnt[0] ? r_magic[idmd_pkg::WORD_W-1:idmd_pkg::HALF_W]
                                 : r_magic[idmd_pkg::HALF_W-1:0];
            end
            S_R_MUL: begin
                mul_a = r_q[idmd_pkg::HALF_W-1:0];
                mul_b = idmd_pkg::HALF_W'(r_d);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // Partial product weight in half words: low-low 0, cross terms 1, high-high 2.
    assign pp_off  = {1'b0, r_cnt[0]} + {1'b0, r_cnt[1]};
    assign acc_sum = r_acc + ({{idmd_pkg::WORD_W{1'b0}}, r_pp} << {r_pp_off, 5'b0});
    assign t_hi    = r_acc[2*idmd_pkg::WORD_W-1:idmd_pkg::WORD_W];

    // Search for ceil(log2 d) one power at a time.
    assign d_ext  = {1'b0, r_d};
    assign pow_lt = r_pow < d_ext;
    assign pow_eq = (r_pow == d_ext);

    // One restoring division step of the reciprocal.
    assign rem_dbl = {r_rem, 1'b0};
    assign rem_ge  = rem_dbl >= d_ext;
    assign rem_sub = rem_dbl - d_ext;

    // Shared right shifter: plain shift for powers of two, final shift otherwise.
    assign shf_src = r_shift_only ? r_x : r_tmp;
    assign shf_amt = r_shift_only ? r_shamt : (r_shamt - idmd_pkg::SHAMT_W'(1));

    // Sequencer, prepared reciprocal and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_divisor    <= idmd_pkg::DIV_W'(1);
            r_prepared   <= '0;
            r_magic      <= '0;
            r_shamt      <= '0;
            r_shift_only <= 1'b0;
            r_o_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_divisor <= i_cfg_wdata;
            end

            // The output word is loaded when a result is done and cleared once taken.
            if (r_state == S_R_SUB && out_free) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_x   <= i_dividend;
                        r_d   <= d_eff;
                        r_acc <= '0;
                        r_cnt <= '0;
                        r_pow <= (idmd_pkg::DIV_W+1)'(1);
                        r_lg  <= '0;
                        if (d_eff != r_prepared) begin
                            r_state <= S_PREP_LOG;
                        end else if (r_shift_only) begin
                            r_state <= S_Q_SHF;
                        end else begin
                            r_state <= S_MUL;
                        end
                    end
                end

                // Smallest power of two not below d; equality means a plain shift.
                S_PREP_LOG: begin
                    if (pow_lt) begin
                        r_pow <= {r_pow[idmd_pkg::DIV_W-1:0], 1'b0};
                        r_lg  <= r_lg + idmd_pkg::SHAMT_W'(1);
                    end else if (pow_eq) begin
                        r_magic      <= '0;
                        r_shamt      <= r_lg;
                        r_shift_only <= 1'b1;
                        r_prepared   <= r_d;
                        r_state      <= S_Q_SHF;
                    end else begin
                        r_rem   <= idmd_pkg::DIV_W'(r_pow - d_ext);
                        r_cnt   <= '0;
                        r_state <= S_PREP_DIV;
                    end
                end

                // floor(2^64 * (2^l - d) / d), one quotient bit per cycle.
                S_PREP_DIV: begin
                    r_rem   <= rem_ge ? rem_sub[idmd_pkg::DIV_W-1:0]
                                      : rem_dbl[idmd_pkg::DIV_W-1:0];
                    r_magic <= {r_magic[idmd_pkg::WORD_W-2:0], rem_ge};
                    r_cnt   <= r_cnt + idmd_pkg::CNT_W'(1);
                    if (r_cnt == {idmd_pkg::CNT_W{1'b1}}) begin
                        r_state <= S_PREP_FIN;
                    end
                end

                S_PREP_FIN: begin
                    r_magic      <= r_magic + idmd_pkg::WORD_W'(1);
                    r_shamt      <= r_lg;
                    r_shift_only <= 1'b0;
                    r_prepared   <= r_d;
                    r_acc        <= '0;
                    r_cnt        <= '0;
                    r_state      <= S_MUL;
                end

                // Multiply-high: each partial product is registered in r_pp, then added into r_acc.
                S_MUL: begin
                    if (r_cnt < idmd_pkg::CNT_W'(idmd_pkg::MUL_STEPS)) begin
                        r_pp     <= mul_p;
                        r_pp_off <= pp_off;
                    end
                    if (r_cnt != '0) begin
                        r_acc <= acc_sum;
                    end
                    if (r_cnt == idmd_pkg::CNT_W'(idmd_pkg::MUL_STEPS)) begin
                        r_state <= S_Q_SUB;
                    end else begin
                        r_cnt <= r_cnt + idmd_pkg::CNT_W'(1);
                    end
                end

                S_Q_SUB: begin
                    r_tmp   <= r_x - t_hi;
                    r_state <= S_Q_ADD;
                end

                S_Q_ADD: begin
                    r_tmp   <= t_hi + (r_tmp >> 1);
                    r_state <= S_Q_SHF;
                end

                S_Q_SHF: begin
                    r_q     <= shf_src >> shf_amt;
                    r_state <= S_R_MUL;
                end

                S_R_MUL: begin
                    r_pp    <= mul_p;
                    r_state <= S_R_SUB;
                end

                // Remainder is below 2^31, so the low bits of x - q*d are enough.
                S_R_SUB: begin
                    if (out_free) begin
                        r_o_quotient  <= r_q;
                        r_o_remainder <= r_x[idmd_pkg::DIV_W-1:0] - r_pp[idmd_pkg::DIV_W-1:0];
                        r_state       <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid     = r_o_valid;
    assign o_quotient  = r_o_quotient;
    assign o_remainder = r_o_remainder;

    // Checks on the sequencer and the arithmetic.
    `IDMD_ASSERT_NOW(a_rem_below_div, o_valid, o_remainder < r_d, "remainder not below divisor")
    `IDMD_ASSERT_NOW(a_mul_prepared, r_state == S_MUL,
                     !r_shift_only && r_prepared == r_d, "multiply without a prepared reciprocal")
    `IDMD_ASSERT_NEXT(a_prep_done, r_state == S_PREP_FIN,
                      r_prepared == r_d && r_state == S_MUL, "reciprocal preparation did not finish")

endmodule

FILE: bench/tb_top.sv
// Self-checking bench for the invariant divisor magic division block.
`timescale 1ns / 1ps

module tb_top;

    localparam int NUM_ROWS     = 20;
    localparam int NUM_CHUNKS   = 12;
    localparam int CHUNK_WORDS  = 46;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE_CYCLES = 150;

    // One quotient and remainder pair as the block should return it.
    typedef struct packed {
        logic [idmd_pkg::WORD_W-1:0] quotient;
        logic [idmd_pkg::DIV_W-1:0]  remainder;
    } t_div_result;

    // One row of the directed stimulus table.
    typedef struct packed {
        bit                          set_div;
        logic [idmd_pkg::DIV_W-1:0]  div;
        logic [idmd_pkg::WORD_W-1:0] dividend;
        bit                          typed;
        logic [idmd_pkg::WORD_W-1:0] quotient;
        logic [idmd_pkg::DIV_W-1:0]  remainder;
    } t_dir_row;

    logic                          i_clk;
    logic                          i_rst_n = 1'b0;
    logic                          i_cfg_we = 1'b0;
    logic [idmd_pkg::DIV_W-1:0]    i_cfg_wdata = '0;
    logic                          i_valid = 1'b0;
    logic                          o_stall;
    logic [idmd_pkg::WORD_W-1:0]   i_dividend = '0;
    logic                          o_valid;
    logic                          i_stall = 1'b0;
    logic [idmd_pkg::WORD_W-1:0]   o_quotient;
    logic [idmd_pkg::DIV_W-1:0]    o_remainder;

    // Bench copy of the divisor register and of the prepared reciprocal.
    logic [idmd_pkg::DIV_W-1:0]    cfg_divisor = 31'd1;
    logic [idmd_pkg::DIV_W-1:0]    rc_prepared = '0;
    logic [idmd_pkg::WORD_W-1:0]   rc_magic = '0;
    logic [idmd_pkg::SHAMT_W-1:0]  rc_shift = '0;
    logic                          rc_shift_only = 1'b0;

    t_div_result         quotient_queue[$];
    int                  mismatches = 0;
    int                  send_idle_pct = 0;
    int                  recv_stall_pct = 0;
    int                  hold_req = 0;
    int                  hold_seen = 0;
    int                  hold_left = 0;

    // Directed words: extremes, zero and one divisors, powers of two, odd and even divisors.
    t_dir_row dir_rows [0:NUM_ROWS-1] = '{
        '{1'b0, 31'd0, 64'd0, 1'b1, 64'd0, 31'd0},
        '{1'b0, 31'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 31'd0},
        '{1'b1, 31'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 31'd0},
        '{1'b0, 31'd0, 64'd123, 1'b1, 64'd123, 31'd0},
        '{1'b1, 31'd1, 64'h5555_5555_5555_5555, 1'b1, 64'h5555_5555_5555_5555, 31'd0},
        '{1'b1, 31'd2, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'h7FFF_FFFF_FFFF_FFFF, 31'd1},
        '{1'b1, 31'h4000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'h3_FFFF_FFFF,
          31'h3FFF_FFFF},
        '{1'b1, 31'h7FFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'd0, 31'd0},
        '{1'b0, 31'd0, 64'd0, 1'b1, 64'd0, 31'd0},
        '{1'b0, 31'd0, 64'd2147483646, 1'b1, 64'd0, 31'h7FFF_FFFE},
        '{1'b0, 31'd0, 64'd2147483647, 1'b1, 64'd1, 31'd0},
        '{1'b1, 31'd3, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'h5555_5555_5555_5555, 31'd0},
        '{1'b0, 31'd0, 64'hAAAA_AAAA_AAAA_AAAB, 1'b0, 64'd0, 31'd0},
        '{1'b1, 31'd7, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'd0, 31'd0},
        '{1'b1, 31'h4000_0001, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'd0, 31'd0},
        '{1'b1, 31'h7FFF_FFFE, 64'h8000_0000_0000_0000, 1'b0, 64'd0, 31'd0},
        '{1'b0, 31'd0, 64'h0123_4567_89AB_CDEF, 1'b0, 64'd0, 31'd0},
        '{1'b1, 31'd10, 64'd1234567890123, 1'b0, 64'd0, 31'd0},
        '{1'b0, 31'd0, 64'd9, 1'b1, 64'd0, 31'd9},
        '{1'b1, 31'h2AAA_AAAB, 64'hDEAD_BEEF_0BAD_F00D, 1'b0, 64'd0, 31'd0}
    };

    invariant_divisor_magic_division DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_dividend  (i_dividend),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_quotient  (o_quotient),
        .o_remainder (o_remainder)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Hard limit on the whole run.
    initial begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Derive the reciprocal for a new divisor: a shift for one or a power of two,
    // otherwise the round-up magic word and ceil(log2 d).
    function automatic void prepare_reciprocal(input logic [idmd_pkg::DIV_W-1:0] d);
        int          l;
        logic [63:0] rem;
        logic [63:0] quo;
        rc_prepared = d;
        if (d <= 1) begin
            rc_magic = '0;
            rc_shift = '0;
            rc_shift_only = 1'b1;
            return;
        end
        if ((d & (d - 1'b1)) == 0) begin
            rc_magic = '0;
            rc_shift = '0;
            while (d[rc_shift] == 1'b0) rc_shift = rc_shift + 1'b1;
            rc_shift_only = 1'b1;
            return;
        end
        l = 0;
        while ((64'd1 << l) < {33'd0, d}) l++;
        rem = (64'd1 << l) - {33'd0, d};
        quo = '0;
        for (int i = 0; i < 64; i++) begin
            rem = rem << 1;
            quo = quo << 1;
            if (rem >= {33'd0, d}) begin
                rem = rem - {33'd0, d};
                quo[0] = 1'b1;
            end
        end
        rc_magic = quo + 64'd1;
        rc_shift = idmd_pkg::SHAMT_W'(l);
        rc_shift_only = 1'b0;
    endfunction

    // Quotient and remainder of one dividend under the current divisor.
    function automatic t_div_result divide_word(input logic [idmd_pkg::WORD_W-1:0] x);
        logic [idmd_pkg::DIV_W-1:0]   d;
        logic [127:0]                 prod;
        logic [63:0]                  t;
        logic [idmd_pkg::SHAMT_W-1:0] s;
        logic [63:0]                  q;
        logic [63:0]                  diff;
        t_div_result                  res;
        d = (cfg_divisor == 0) ? 31'd1 : cfg_divisor;
        if (d != rc_prepared) prepare_reciprocal(d);
        if (rc_shift_only) begin
            q = x >> rc_shift;
        end else begin
            prod = {64'd0, x} * {64'd0, rc_magic};
            t = prod[127:64];
            s = rc_shift - 1'b1;
            q = (t + ((x - t) >> 1)) >> s;
        end
        diff = x - q * {33'd0, d};
        res.quotient = q;
        res.remainder = (d <= 1) ? '0 : diff[idmd_pkg::DIV_W-1:0];
        return res;
    endfunction

    // Print one line per mismatch and count it.
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
        mismatches++;
    endtask

    // Offer one dividend word and record its expected result once it is taken.
    task automatic send_word(input logic [idmd_pkg::WORD_W-1:0] x,
                             input bit typed,
                             input logic [idmd_pkg::WORD_W-1:0] tq,
                             input logic [idmd_pkg::DIV_W-1:0] tr);
        t_div_result res;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_dividend <= x;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        res = divide_word(x);
        if (typed) begin
            res.quotient = tq;
            res.remainder = tr;
        end
        quotient_queue.insert(quotient_queue.size(), res);
    endtask

    // Let every result drain, then write the divisor register.
    task automatic write_divisor(input logic [idmd_pkg::DIV_W-1:0] d);
        i_valid <= 1'b0;
        while (quotient_queue.size() != 0) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= d;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_divisor = d;
    endtask

    // Divisor for one random phase, spread over powers of two, small and full range.
    function automatic logic [idmd_pkg::DIV_W-1:0] pick_divisor();
        case ($urandom_range(4))
            0: return 31'd1 << $urandom_range(30);
            1: return idmd_pkg::DIV_W'($urandom_range(100, 2));
            2: return idmd_pkg::DIV_W'($urandom_range(65535, 3));
            3: return 31'h7FFF_FFFF - idmd_pkg::DIV_W'($urandom_range(50));
            default: return idmd_pkg::DIV_W'($urandom_range(32'h7FFF_FFFF, 0));
        endcase
    endfunction

    // Dividend that favors small values, near multiples and the top of the range.
    function automatic logic [idmd_pkg::WORD_W-1:0] rand_dividend(
        input logic [idmd_pkg::DIV_W-1:0] d);
        logic [63:0] dd;
        logic [63:0] base;
        dd = (d == 0) ? 64'd1 : {33'd0, d};
        case ($urandom_range(4))
            0: return {$urandom, $urandom};
            1: return 64'($urandom_range(1000));
            2: begin
                base = {$urandom, $urandom} >> $urandom_range(63, 31);
                return base * dd + ($urandom_range(1) ? dd - 64'd1 : 64'd0);
            end
            3: return ~64'($urandom_range(1000));
            default: return {$urandom, $urandom} >> $urandom_range(63);
        endcase
    endfunction

    // Receiver: random stall, or a long counted hold-off when one is requested.
    always @(posedge i_clk) begin
        if (hold_seen != hold_req) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            i_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Compare each accepted result word with the oldest expectation.
    always @(posedge i_clk) begin
        t_div_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (quotient_queue.size() == 0) begin
                report_mismatch("unexpected word, quotient", o_quotient, 64'd0);
            end else begin
                want = quotient_queue.pop_front();
                if (o_quotient !== want.quotient)
                    report_mismatch("quotient", o_quotient, want.quotient);
                if (o_remainder !== want.remainder)
                    report_mismatch("remainder", {33'd0, o_remainder},
                                    {33'd0, want.remainder});
            end
        end
    end

    // Main sequence: reset, directed table, random phases, drain and verdict.
    initial begin
        logic [idmd_pkg::DIV_W-1:0] d;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table.
        for (int r = 0; r < NUM_ROWS; r++) begin
            if (dir_rows[r].set_div) write_divisor(dir_rows[r].div);
            send_word(dir_rows[r].dividend, dir_rows[r].typed,
                      dir_rows[r].quotient, dir_rows[r].remainder);
        end

        // Random phases, each with its own divisor and idling pattern.
        for (int c = 0; c < NUM_CHUNKS; c++) begin
            if (c == 0) d = 31'h7FFF_FFFF;
            else if (c == 1) d = 31'd1;
            else if (c == 2) d = 31'd0;
            else d = pick_divisor();
            write_divisor(d);
            case (c % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
                1: begin send_idle_pct = 51; recv_stall_pct <= 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct <= 51; end
                default: begin send_idle_pct = 28; recv_stall_pct <= 28; end
            endcase
            for (int k = 0; k < CHUNK_WORDS; k++) begin
                // Long receiver hold-off while words keep coming.
                if (c == 5 && k == 5) hold_req <= hold_req + 1;
                // Sender pauses until every result is back.
                if (c == 8 && k == 20) begin
                    i_valid <= 1'b0;
                    @(posedge i_clk);
                    while (quotient_queue.size() != 0) @(posedge i_clk);
                end
                send_word(rand_dividend(d), 1'b0, '0, '0);
            end
        end

        i_valid <= 1'b0;
        while (quotient_queue.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && quotient_queue.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
